### src/glq_pkg.sv
// Shared types, codes and helpers for the glyph quad layout unit.
// No dependencies; imported by every module of the block.
package glq_pkg;

    localparam logic [1:0] CMD_GLYPH = 2'd0;
    localparam logic [1:0] CMD_KERN  = 2'd1;
    localparam logic [1:0] CMD_CHAR  = 2'd2;

    localparam logic [7:0] FALLBACK_CHAR = 8'd61;
    localparam logic [7:0] NEWLINE_CHAR  = 8'd10;
    localparam logic [8:0] PREV_NONE     = 9'h100;

    localparam int IN_DATA_W  = 96;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 80;

    typedef struct packed {
        logic [11:0] ax;
        logic [11:0] ay;
        logic [7:0]  w;
        logic [7:0]  h;
        logic [7:0]  ox;
        logic [7:0]  oy;
        logic [7:0]  adv;
    } t_glyph;

    typedef struct packed {
        logic       start;
        logic       append;
        logic [8:0] first;
        logic [7:0] second;
        logic [7:0] amount;
    } t_kern_req;

    typedef struct packed {
        logic       busy;
        logic [7:0] amount;
    } t_kern_rsp;

    typedef struct packed {
        logic [18:0] x0;
        logic [18:0] y0;
        logic [7:0]  w;
        logic [7:0]  h;
        logic [11:0] ax;
        logic [11:0] ay;
        logic [15:0] vidx;
    } t_quad;

    function automatic logic [15:0] sat16(input logic [18:0] v);
        logic signed [18:0] s;
        s = $signed(v);
        if (s > 19'sd32767) begin
            return 16'h7fff;
        end else if (s < -19'sd32768) begin
            return 16'h8000;
        end
        return v[15:0];
    endfunction

    function automatic logic [18:0] sx8(input logic [7:0] v);
        return {{11{v[7]}}, v};
    endfunction

    function automatic logic [18:0] sx16(input logic [15:0] v);
        return {{3{v[15]}}, v};
    endfunction

endpackage

### src/glq_glyph_store.sv
// Glyph store: synchronous glyph memory with registered read and present bits.
// Depends on glq_pkg.
module glq_glyph_store #(
    parameter int GLYPH_ENTRIES = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_en,
    input  logic [7:0]     i_wr_addr,
    input  glq_pkg::t_glyph i_wr_data,
    input  logic [7:0]     i_rd_addr,
    output glq_pkg::t_glyph o_rd_data,
    output logic           o_rd_hit
);
    import glq_pkg::*;

    localparam int GW = $clog2(GLYPH_ENTRIES);

    t_glyph r_mem [GLYPH_ENTRIES];
    logic   r_present [GLYPH_ENTRIES];
    t_glyph r_rd_data;
    logic   r_rd_hit;
    logic   wr_ok;
    logic   rd_ok;

    assign wr_ok = i_wr_en && (9'(i_wr_addr) < 9'(GLYPH_ENTRIES));
    assign rd_ok = 9'(i_rd_addr) < 9'(GLYPH_ENTRIES);

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[i_wr_addr[GW-1:0]] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr[GW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < GLYPH_ENTRIES; i++) begin
                r_present[i] <= 1'b0;
            end
            r_rd_hit <= 1'b0;
        end else begin
            if (wr_ok) begin
                r_present[i_wr_addr[GW-1:0]] <= 1'b1;
            end
            r_rd_hit <= rd_ok && r_present[i_rd_addr[GW-1:0]];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_rd_hit  = r_rd_hit;

endmodule

### src/glq_kern_table.sv
// Kerning pair memory with append pointer and a linear first-match search,
// one pair read per cycle. Depends on glq_pkg.
module glq_kern_table #(
    parameter int KERN_ENTRIES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  glq_pkg::t_kern_req i_req,
    output glq_pkg::t_kern_rsp o_rsp
);
    import glq_pkg::*;

    localparam int CW = $clog2(KERN_ENTRIES + 1);
    localparam int AW = (KERN_ENTRIES > 1) ? $clog2(KERN_ENTRIES) : 1;

    logic [23:0]   r_mem [KERN_ENTRIES];
    logic [23:0]   r_rd;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_idx;
    logic          r_busy;
    logic          r_chk;
    logic [8:0]    r_first;
    logic [7:0]    r_second;
    logic [7:0]    r_amount;
    logic          wr_ok;
    logic          match;
    logic          issue;

    assign wr_ok = i_req.append && (r_cnt < CW'(KERN_ENTRIES));
    assign match = r_chk && (r_first == {1'b0, r_rd[23:16]}) && (r_second == r_rd[15:8]);
    assign issue = r_busy && !match && (r_idx < r_cnt);

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_cnt[AW-1:0]] <= {i_req.first[7:0], i_req.second, i_req.amount};
        end
        if (issue) begin
            r_rd <= r_mem[r_idx[AW-1:0]];
        end
        if (i_req.start) begin
            r_first  <= i_req.first;
            r_second <= i_req.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_idx    <= '0;
            r_busy   <= 1'b0;
            r_chk    <= 1'b0;
            r_amount <= '0;
        end else begin
            if (wr_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_chk  <= 1'b0;
            end else if (r_busy) begin
                priority if (match) begin
                    r_amount <= r_rd[7:0];
                    r_busy   <= 1'b0;
                    r_chk    <= 1'b0;
                end else if (issue) begin
                    r_idx <= r_idx + 1'b1;
                    r_chk <= 1'b1;
                end else begin
                    r_amount <= '0;
                    r_busy   <= 1'b0;
                    r_chk    <= 1'b0;
                end
            end
        end
    end

    assign o_rsp = '{busy: r_busy, amount: r_amount};

endmodule

### src/glq_quad_emit.sv
// Quad emitter: steps the four corners of a loaded quad into the output register.
// Depends on glq_pkg.
module glq_quad_emit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  glq_pkg::t_quad        i_quad,
    output logic                  o_busy,
    output logic                  o_tvalid,
    input  logic                  i_tready,
    output logic [glq_pkg::OUT_DATA_W-1:0] o_tdata,
    output logic                  o_tlast
);
    import glq_pkg::*;

    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_TR = 2'd1;
    localparam logic [1:0] CORNER_BR = 2'd2;
    localparam logic [1:0] CORNER_BL = 2'd3;

    t_quad                 r_quad;
    logic [1:0]            r_corner;
    logic                  r_busy;
    logic                  r_valid;
    logic [OUT_DATA_W-1:0] r_data;
    logic                  r_last;
    logic                  adv;
    logic                  right;
    logic                  bottom;
    logic [18:0]           px;
    logic [18:0]           py;
    logic [12:0]           tx;
    logic [12:0]           ty;

    assign adv    = r_busy && (!r_valid || i_tready);
    assign right  = (r_corner == CORNER_TR) || (r_corner == CORNER_BR);
    assign bottom = (r_corner == CORNER_BR) || (r_corner == CORNER_BL);
    assign px = r_quad.x0 + (right ? {11'd0, r_quad.w} : 19'd0);
    assign py = r_quad.y0 - (bottom ? {11'd0, r_quad.h} : 19'd0);
    assign tx = {1'b0, r_quad.ax} + (right ? {5'd0, r_quad.w} : 13'd0);
    assign ty = {1'b0, r_quad.ay} + (bottom ? {5'd0, r_quad.h} : 13'd0);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_quad <= i_quad;
        end
        if (adv) begin
            r_data <= {6'd0, ty, tx, sat16(py), sat16(px), r_quad.vidx + 16'(r_corner)};
            r_last <= (r_corner == CORNER_BL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_valid  <= 1'b0;
            r_corner <= CORNER_TL;
        end else begin
            if (i_load) begin
                r_busy   <= 1'b1;
                r_corner <= CORNER_TL;
            end else if (adv) begin
                r_corner <= r_corner + 1'b1;
                if (r_corner == CORNER_BL) begin
                    r_busy <= 1'b0;
                end
            end
            if (adv) begin
                r_valid <= 1'b1;
            end else if (i_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_busy   = r_busy;
    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tlast  = r_last;

endmodule

### src/glyph_quad_layout_unit.sv
// Top level of the glyph quad layout unit: command decode, pen state, sequencing.
// Depends on glq_pkg, glq_glyph_store, glq_kern_table and glq_quad_emit.
//
//   channel   dir   handshake             payload
//   s         in    i_s_tvalid/o_s_tready  i_s_tdata, i_s_tuser (command)
//   m         out   o_m_tvalid/i_m_tready  o_m_tdata, o_m_tlast (last corner)
//   cfg       in    i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// Glyph writes and kerning appends are taken without leaving the idle state.
// A character reads its glyph, reads the fallback glyph when that one is missing,
// then waits for the kerning scan (one pair per cycle from the kerning memory port)
// and for a free emitter, and then loads the quad.
// The four vertices drain from the output register while the next item is taken;
// a quad loads only once the emitter is free, later while the output stalls.
// Reset is synchronous; present bits all clear together, no clearing pass.
// A stalled output holds the emitter; the next character waits until it is free.
module glyph_quad_layout_unit #(
    parameter int GLYPH_ENTRIES = 256,
    parameter int KERN_ENTRIES  = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // char_code, new_string, atlas_x, atlas_y, glyph_width, glyph_height,
    // offset_x, offset_y, advance, kern_second, kern_amount, zero fill
    input  logic [glq_pkg::IN_DATA_W-1:0] i_s_tdata,
    // command
    input  logic [glq_pkg::IN_USER_W-1:0] i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // vertex_index, pos_x, pos_y, tex_x, tex_y, zero fill
    output logic [glq_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic                          o_m_tlast,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [15:0]                   i_cfg_data
);
    import glq_pkg::*;

    localparam logic [1:0] CFG_START_X     = 2'd0;
    localparam logic [1:0] CFG_START_Y     = 2'd1;
    localparam logic [1:0] CFG_LINE_HEIGHT = 2'd2;

    typedef enum logic [1:0] {S_IDLE, S_GLYPH, S_FALLBACK, S_WAIT} t_state;

    t_state      r_state;
    logic [15:0] r_start_x;
    logic [15:0] r_start_y;
    logic [7:0]  r_line_height;
    logic [15:0] r_pen_x;
    logic [15:0] r_pen_y;
    logic [8:0]  r_prev;
    logic [15:0] r_vcount;
    logic [7:0]  r_ch;
    t_glyph      r_glyph;

    logic        acc;
    logic [1:0]  cmd;
    logic [7:0]  ch;
    logic        new_str;
    t_glyph      in_glyph;
    t_glyph      gs_data;
    logic        gs_hit;
    t_kern_req   kern_req;
    t_kern_rsp   kern_rsp;
    logic        em_busy;
    logic        load;
    t_quad       quad;
    logic [15:0] base_x;
    logic [15:0] base_y;
    logic [15:0] n_pen_x;
    logic [15:0] n_pen_y;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign acc     = i_s_tvalid && o_s_tready;
    assign cmd     = i_s_tuser;
    assign ch      = i_s_tdata[7:0];
    assign new_str = i_s_tdata[8];

    assign in_glyph = '{ax: i_s_tdata[20:9], ay: i_s_tdata[32:21], w: i_s_tdata[40:33],
                        h: i_s_tdata[48:41], ox: i_s_tdata[56:49], oy: i_s_tdata[64:57],
                        adv: i_s_tdata[72:65]};

    assign kern_req = '{start:  acc && (cmd == CMD_CHAR),
                        append: acc && (cmd == CMD_KERN),
                        first:  (cmd == CMD_CHAR) ? (new_str ? PREV_NONE : r_prev)
                                                  : {1'b0, ch},
                        second: (cmd == CMD_CHAR) ? ch : i_s_tdata[80:73],
                        amount: i_s_tdata[88:81]};

    assign base_x  = new_str ? r_start_x : r_pen_x;
    assign base_y  = new_str ? r_start_y : r_pen_y;
    assign n_pen_x = (ch == NEWLINE_CHAR) ? r_start_x : base_x;
    assign n_pen_y = (ch == NEWLINE_CHAR) ? sat16(sx16(base_y) + {11'd0, r_line_height})
                                          : base_y;

    assign load = (r_state == S_WAIT) && !kern_rsp.busy && !em_busy;

    assign quad = '{x0: sx16(r_pen_x) + sx8(r_glyph.ox) + sx8(kern_rsp.amount),
                    y0: sx16(r_pen_y) - sx8(r_glyph.oy),
                    w: r_glyph.w, h: r_glyph.h, ax: r_glyph.ax, ay: r_glyph.ay,
                    vidx: r_vcount};

    glq_glyph_store #(
        .GLYPH_ENTRIES(GLYPH_ENTRIES)
    ) u_glyph (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (acc && (cmd == CMD_GLYPH)),
        .i_wr_addr (ch),
        .i_wr_data (in_glyph),
        .i_rd_addr ((r_state == S_IDLE) ? ch : FALLBACK_CHAR),
        .o_rd_data (gs_data),
        .o_rd_hit  (gs_hit)
    );

    glq_kern_table #(
        .KERN_ENTRIES(KERN_ENTRIES)
    ) u_kern (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (kern_req),
        .o_rsp   (kern_rsp)
    );

    glq_quad_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_quad   (quad),
        .o_busy   (em_busy),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tlast  (o_m_tlast)
    );

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_ch <= ch;
        end
        if (r_state == S_GLYPH && gs_hit) begin
            r_glyph <= gs_data;
        end else if (r_state == S_FALLBACK) begin
            r_glyph <= gs_hit ? gs_data : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_start_x     <= '0;
            r_start_y     <= '0;
            r_line_height <= 8'd16;
            r_pen_x       <= '0;
            r_pen_y       <= '0;
            r_prev        <= PREV_NONE;
            r_vcount      <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_START_X:     r_start_x     <= i_cfg_data;
                    CFG_START_Y:     r_start_y     <= i_cfg_data;
                    CFG_LINE_HEIGHT: r_line_height <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (acc && cmd == CMD_CHAR) begin
                        r_pen_x <= n_pen_x;
                        r_pen_y <= n_pen_y;
                        if (new_str) begin
                            r_vcount <= '0;
                        end
                        r_state <= S_GLYPH;
                    end
                end
                S_GLYPH: begin
                    r_state <= gs_hit ? S_WAIT : S_FALLBACK;
                end
                S_FALLBACK: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (load) begin
                        r_pen_x  <= sat16(sx16(r_pen_x) + {11'd0, r_glyph.adv});
                        r_prev   <= {1'b0, r_ch};
                        r_vcount <= r_vcount + 16'd4;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### sim/tb.sv
// Self-checking testbench for glyph_quad_layout_unit: glyph writes, kerning
// appends and characters in directed and random phases, vertices checked against a
// local layout predictor. Depends on glq_pkg and the unit's RTL.
module tb;
    import glq_pkg::*;

    localparam logic [1:0] CMD_UNUSED      = 2'd3;
    localparam logic [1:0] REG_START_X     = 2'd0;
    localparam logic [1:0] REG_START_Y     = 2'd1;
    localparam logic [1:0] REG_LINE_HEIGHT = 2'd2;
    localparam int KERN_CAP    = 64;
    localparam int SETTLE      = 100;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [1:0]  cmd;
        logic [7:0]  code;
        logic        fresh;
        logic [11:0] ax;
        logic [11:0] ay;
        logic [7:0]  w;
        logic [7:0]  h;
        logic [7:0]  ox;
        logic [7:0]  oy;
        logic [7:0]  adv;
        logic [7:0]  second;
        logic [7:0]  amount;
    } t_layout_item;

    typedef struct {
        int ax, ay, w, h, ox, oy, adv;
    } t_glyph_rec;

    typedef struct {
        logic [15:0] vidx;
        logic [15:0] px;
        logic [15:0] py;
        logic [12:0] tx;
        logic [12:0] ty;
        logic        last;
    } t_vertex_rec;

    class quad_layout_model;
        t_glyph_rec  glyphs[256];
        bit          present[256];
        logic [7:0]  kern_first[KERN_CAP];
        logic [7:0]  kern_second[KERN_CAP];
        int          kern_amount[KERN_CAP];
        int          kern_count;
        int          pen_x;
        int          pen_y;
        logic [8:0]  prev_char;
        logic [15:0] vidx;
        logic [15:0] start_x;
        logic [15:0] start_y;
        logic [7:0]  line_height;
        t_vertex_rec pending_vertices[$];
        int          mismatches;

        function new();
            foreach (present[i]) present[i] = 1'b0;
            kern_count  = 0;
            pen_x       = 0;
            pen_y       = 0;
            prev_char   = PREV_NONE;
            vidx        = '0;
            start_x     = '0;
            start_y     = '0;
            line_height = 8'd16;
            mismatches  = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                REG_START_X:     start_x = val;
                REG_START_Y:     start_y = val;
                REG_LINE_HEIGHT: line_height = val[7:0];
                default: ;
            endcase
        endfunction

        function int clip16(int v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return v;
        endfunction

        function int kern_for(logic [8:0] first, logic [7:0] second);
            for (int i = 0; i < kern_count; i++) begin
                if ({1'b0, kern_first[i]} == first && kern_second[i] == second) begin
                    return kern_amount[i];
                end
            end
            return 0;
        endfunction

        function void push_vertex(int px, int py, int tx, int ty, bit last);
            t_vertex_rec v;
            v.vidx = vidx;
            v.px   = 16'(clip16(px));
            v.py   = 16'(clip16(py));
            v.tx   = 13'(tx);
            v.ty   = 13'(ty);
            v.last = last;
            pending_vertices.push_back(v);
            vidx++;
        endfunction

        function void note_item(logic [1:0] cmd, logic [95:0] d);
            logic [7:0] code;
            t_glyph_rec g;
            int x0, x1, y0, y1;
            code = d[7:0];
            case (cmd)
                CMD_GLYPH: begin
                    g.ax  = d[20:9];
                    g.ay  = d[32:21];
                    g.w   = d[40:33];
                    g.h   = d[48:41];
                    g.ox  = $signed(d[56:49]);
                    g.oy  = $signed(d[64:57]);
                    g.adv = d[72:65];
                    glyphs[code]  = g;
                    present[code] = 1'b1;
                end
                CMD_KERN: begin
                    if (kern_count < KERN_CAP) begin
                        kern_first[kern_count]  = code;
                        kern_second[kern_count] = d[80:73];
                        kern_amount[kern_count] = $signed(d[88:81]);
                        kern_count++;
                    end
                end
                CMD_CHAR: begin
                    if (d[8]) begin
                        pen_x     = $signed(start_x);
                        pen_y     = $signed(start_y);
                        prev_char = PREV_NONE;
                        vidx      = '0;
                    end
                    if (present[code]) begin
                        g = glyphs[code];
                    end else if (present[FALLBACK_CHAR]) begin
                        g = glyphs[FALLBACK_CHAR];
                    end else begin
                        g = '{default: 0};
                    end
                    if (code == NEWLINE_CHAR) begin
                        pen_y = clip16(pen_y + int'(line_height));
                        pen_x = $signed(start_x);
                    end
                    x0 = pen_x + g.ox + kern_for(prev_char, code);
                    x1 = x0 + g.w;
                    y0 = pen_y - g.oy;
                    y1 = y0 - g.h;
                    push_vertex(x0, y0, g.ax, g.ay, 1'b0);
                    push_vertex(x1, y0, g.ax + g.w, g.ay, 1'b0);
                    push_vertex(x1, y1, g.ax + g.w, g.ay + g.h, 1'b0);
                    push_vertex(x0, y1, g.ax, g.ay + g.h, 1'b1);
                    pen_x     = clip16(pen_x + g.adv);
                    prev_char = {1'b0, code};
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [15:0] exp, logic [15:0] act);
            if (exp !== act) begin
                $error("%s expected 0x%0h actual 0x%0h", name, exp, act);
                mismatches++;
            end
        endfunction

        function void check_vertex(logic [79:0] d, logic last);
            t_vertex_rec e;
            if (pending_vertices.size() == 0) begin
                $error("vertex_index %0d arrived with nothing expected", d[15:0]);
                mismatches++;
                return;
            end
            e = pending_vertices.pop_front();
            compare_field("vertex_index", e.vidx, d[15:0]);
            compare_field("pos_x", e.px, d[31:16]);
            compare_field("pos_y", e.py, d[47:32]);
            compare_field("tex_x", 16'(e.tx), 16'(d[60:48]));
            compare_field("tex_y", 16'(e.ty), 16'(d[73:61]));
            compare_field("last_corner", 16'(e.last), 16'(last));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    quad_layout_model layout = new();
    bit gaps_on = 1'b1;
    bit stall_on = 1'b1;
    int cycle_count = 0;

    glyph_quad_layout_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_tvalid && s_tready) begin
            layout.note_item(s_tuser, s_tdata);
        end
        if (i_rst_n && m_tvalid && m_tready) begin
            layout.check_vertex(m_tdata, m_tlast);
        end
    end

    // output backpressure in bursts
    initial begin
        @(posedge i_rst_n);
        forever begin
            if (stall_on && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
    end

    function automatic logic [95:0] pack_item(t_layout_item it);
        return {7'b0, it.amount, it.second, it.adv, it.oy, it.ox, it.h, it.w,
                it.ay, it.ax, it.fresh, it.code};
    endfunction

    function automatic t_layout_item noise_item(logic [1:0] cmd, logic [7:0] code);
        t_layout_item it;
        it.cmd    = cmd;
        it.code   = code;
        it.fresh  = 1'($urandom);
        it.ax     = 12'($urandom);
        it.ay     = 12'($urandom);
        it.w      = 8'($urandom);
        it.h      = 8'($urandom);
        it.ox     = 8'($urandom);
        it.oy     = 8'($urandom);
        it.adv    = 8'($urandom);
        it.second = 8'($urandom);
        it.amount = 8'($urandom);
        return it;
    endfunction

    function automatic t_layout_item glyph_item(logic [7:0] code, logic [11:0] ax,
            logic [11:0] ay, logic [7:0] w, logic [7:0] h, logic [7:0] ox,
            logic [7:0] oy, logic [7:0] adv);
        t_layout_item it;
        it     = noise_item(CMD_GLYPH, code);
        it.ax  = ax;
        it.ay  = ay;
        it.w   = w;
        it.h   = h;
        it.ox  = ox;
        it.oy  = oy;
        it.adv = adv;
        return it;
    endfunction

    function automatic t_layout_item kern_item(logic [7:0] first, logic [7:0] second,
            logic [7:0] amount);
        t_layout_item it;
        it        = noise_item(CMD_KERN, first);
        it.second = second;
        it.amount = amount;
        return it;
    endfunction

    function automatic t_layout_item char_item(logic [7:0] code, logic fresh);
        t_layout_item it;
        it       = noise_item(CMD_CHAR, code);
        it.fresh = fresh;
        return it;
    endfunction

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 9))
            0: return 8'($urandom);
            1: return NEWLINE_CHAR;
            2: return FALLBACK_CHAR;
            default: return 8'd65 + 8'($urandom_range(0, 7));
        endcase
    endfunction

    task automatic send_item(t_layout_item it);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.cmd;
        s_tdata  <= pack_item(it);
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        layout.set_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_layout_regs(logic [15:0] sx, logic [15:0] sy, logic [15:0] lh);
        write_reg(REG_START_X, sx);
        write_reg(REG_START_Y, sy);
        write_reg(REG_LINE_HEIGHT, lh);
    endtask

    // hold input idle until every vertex is back and the unit has settled
    task automatic drain_vertices();
        s_tvalid <= 1'b0;
        while (layout.pending_vertices.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic run_random(int count);
        int done;
        int r;
        done = 0;
        while (done < count) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                send_item(glyph_item(pick_char(), 12'($urandom), 12'($urandom),
                    8'($urandom_range(0, 40)), 8'($urandom_range(0, 40)),
                    8'($urandom), 8'($urandom), 8'($urandom_range(0, 30))));
                done++;
            end else if (r < 32) begin
                send_item(kern_item(pick_char(), pick_char(), 8'($urandom)));
                done++;
            end else if (r < 34) begin
                send_item(noise_item(CMD_UNUSED, 8'($urandom)));
            end else begin
                send_item(char_item(pick_char(), $urandom_range(0, 9) == 0));
                done++;
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: missing glyphs, fallback, kerning order, newline
        send_item(char_item(8'd65, 1'b1));
        send_item(noise_item(CMD_UNUSED, 8'd255));
        send_item(glyph_item(FALLBACK_CHAR, 12'd100, 12'd200, 8'd8, 8'd12,
            8'hfe, 8'd10, 8'd9));
        send_item(char_item(8'd66, 1'b0));
        send_item(glyph_item(8'd255, 12'hfff, 12'hfff, 8'hff, 8'hff, 8'h7f, 8'h80,
            8'hff));
        send_item(glyph_item(8'd0, '0, '0, '0, '0, '0, '0, '0));
        send_item(glyph_item(NEWLINE_CHAR, 12'd1, 12'd2, 8'd3, 8'd4, 8'h80, 8'h7f,
            8'd0));
        send_item(kern_item(8'd255, 8'd255, 8'h7f));
        send_item(kern_item(8'd255, 8'd255, 8'hfb));
        send_item(kern_item(8'd0, 8'd255, 8'h80));
        send_item(char_item(8'd255, 1'b0));
        send_item(char_item(8'd255, 1'b0));
        send_item(char_item(NEWLINE_CHAR, 1'b0));
        send_item(char_item(8'd0, 1'b1));
        send_item(char_item(8'd255, 1'b0));
        drain_vertices();

        // pen at the positive x and negative y limits
        write_layout_regs(16'h7fff, 16'h8000, 16'hffff);
        send_item(char_item(8'd255, 1'b1));
        send_item(char_item(NEWLINE_CHAR, 1'b0));
        send_item(char_item(8'd255, 1'b0));
        send_item(char_item(8'd255, 1'b0));
        drain_vertices();

        // pen at the negative x and positive y limits, zero line height
        write_layout_regs(16'h8000, 16'h7fff, 16'h0000);
        send_item(char_item(FALLBACK_CHAR, 1'b1));
        send_item(char_item(NEWLINE_CHAR, 1'b0));
        send_item(glyph_item(FALLBACK_CHAR, 12'd4000, 12'd5, 8'hff, 8'd1, 8'h80,
            8'h80, 8'd1));
        send_item(char_item(FALLBACK_CHAR, 1'b1));
        drain_vertices();

        for (int p = 0; p < 4; p++) begin
            if (p == 3) begin
                gaps_on  = 1'b0;
                stall_on = 1'b0;
            end
            write_layout_regs(16'($urandom), 16'($urandom), 16'($urandom));
            run_random(100);
            drain_vertices();
        end

        if (layout.mismatches == 0 && layout.pending_vertices.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
